// ===== rtl/fopf_pkg.sv =====
package fopf_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    MODE_PREFIX_BYTE = 2'd0,
    MODE_PREFIX_LEN  = 2'd1,
    MODE_PATH_CHAR   = 2'd2
  } mode_e;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_KEEP_ALL_OPENS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_DOTENV    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_PREFIXES = 2'd2;

  // Write-ish open flags: WRONLY, RDWR, CREAT, TRUNC, APPEND
  localparam logic [31:0] FLAG_WRITE_MASK = 32'h0000_0001 | 32'h0000_0002 |
                                            32'h0000_0040 | 32'h0000_0200 |
                                            32'h0000_0400;

  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_E     = 8'h65;
  localparam logic [7:0] CHAR_N     = 8'h6e;
  localparam logic [7:0] CHAR_V     = 8'h76;
  localparam logic [31:0] DOTENV_HEAD = {CHAR_SLASH, CHAR_DOT, CHAR_E, CHAR_N};

  // One registered input beat
  typedef struct packed {
    mode_e       mode;
    logic [3:0]  slot;
    logic [5:0]  position;
    logic [7:0]  data_value;
    logic [31:0] open_flags;
    logic        last;
  } in_item_t;

endpackage

// ===== rtl/file_open_path_filter_core.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    mode, slot, position, data_value,
//                                             open_flags, last
// out       output     out_valid / out_ready  keep_event, write_intent,
//                                             prefix_matched, dotenv_found
// cfg       input      cfg_write (no wait)    cfg_index, cfg_data
//
// One beat per cycle sustained unless a result stalls. A beat is executed in
// the input register; a verdict shows on out_valid the cycle after that.
// The prefix row RAM read port reads one row per cycle, at the position the
// next path character will use.
// rst is synchronous; the prefix byte RAM is not cleared (no clearing pass).
// A stalled result holds the input register, which drops in_ready.
module file_open_path_filter_core #(
  parameter int PREFIX_SLOTS = 16,
  parameter int PREFIX_BYTES = 64,
  parameter int PATH_BYTES   = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  fopf_pkg::mode_e                      mode,
  input  logic [3:0]                           slot,
  input  logic [5:0]                           position,
  input  logic [7:0]                           data_value,
  input  logic [31:0]                          open_flags,
  input  logic                                 last,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 keep_event,
  output logic                                 write_intent,
  output logic                                 prefix_matched,
  output logic                                 dotenv_found,
  // configuration port
  input  logic                                 cfg_write,
  input  logic [fopf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fopf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fopf_pkg::*;

  localparam int AW   = $clog2(PREFIX_BYTES);                  // RAM row address
  localparam int SLW  = (PREFIX_SLOTS > 1) ? $clog2(PREFIX_SLOTS) : 1;
  localparam int CW   = $clog2(PATH_BYTES);                    // holds PATH_BYTES-1
  localparam int CMPW = (CW > 9) ? CW : 9;                     // length compares

  // Configuration registers
  logic       keep_all_opens;
  logic       check_dotenv;
  logic [4:0] active_prefixes;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_all_opens  <= 1'b0;
      check_dotenv    <= 1'b0;
      active_prefixes <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEEP_ALL_OPENS:  keep_all_opens  <= cfg_data[0];
        REG_CHECK_DOTENV:    check_dotenv    <= cfg_data[0];
        REG_ACTIVE_PREFIXES: active_prefixes <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Input register (execute stage)
  logic     s1_valid;
  in_item_t s1;
  logic     has_result;
  logic     e_fire;

  assign has_result = (s1.mode == MODE_PATH_CHAR) && s1.last;
  assign e_fire     = s1_valid && (!has_result || !out_valid || out_ready);
  assign in_ready   = !s1_valid || e_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1 <= '{mode: mode, slot: slot, position: position, data_value: data_value,
              open_flags: open_flags, last: last};
    end
  end

  // Path state
  logic [PREFIX_SLOTS-1:0] still_matching, still_matching_next;
  logic [CW-1:0]           chars_seen, chars_seen_next;
  logic                    path_ended, path_ended_next;
  logic [31:0]             recent_chars, recent_chars_next;
  logic                    dotenv_seen, dotenv_seen_next;
  logic [7:0]              prefix_lengths [PREFIX_SLOTS];

  // Prefix RAM: one row per byte position, one byte lane per slot
  logic [7:0]     prefix_store [PREFIX_BYTES][PREFIX_SLOTS];
  logic [7:0]     rd_row [PREFIX_SLOTS];
  logic [7:0]     row_eff [PREFIX_SLOTS];
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic [SLW-1:0] ram_wslot;
  logic           fwd_hit;
  logic [SLW-1:0] fwd_slot;
  logic [7:0]     fwd_data;

  assign ram_we    = e_fire && (s1.mode == MODE_PREFIX_BYTE) &&
                     (32'(s1.slot) < PREFIX_SLOTS) && (32'(s1.position) < PREFIX_BYTES);
  assign ram_waddr = AW'(s1.position);
  assign ram_wslot = SLW'(s1.slot);
  // read the row the next character will compare against
  assign ram_raddr = AW'(chars_seen_next);

  always_ff @(posedge clk) begin
    if (ram_we) begin
      prefix_store[ram_waddr][ram_wslot] <= s1.data_value;
    end
    rd_row   <= prefix_store[ram_raddr];
    // same-edge write to the row being read: patch it in next cycle
    fwd_hit  <= ram_we && (ram_waddr == ram_raddr);
    fwd_slot <= ram_wslot;
    fwd_data <= s1.data_value;
  end

  always_comb begin
    for (int i = 0; i < PREFIX_SLOTS; i++) begin
      row_eff[i] = (fwd_hit && (fwd_slot == SLW'(i))) ? fwd_data : rd_row[i];
    end
  end

  // Execute: per-slot compares side by side, window check, verdict
  logic r_keep, r_wi, r_pm, r_dot;

  always_comb begin
    logic take;
    logic c_in_range;
    still_matching_next = still_matching;
    chars_seen_next     = chars_seen;
    path_ended_next     = path_ended;
    recent_chars_next   = recent_chars;
    dotenv_seen_next    = dotenv_seen;
    r_pm  = 1'b0;
    r_wi  = |(s1.open_flags & FLAG_WRITE_MASK);
    r_dot = 1'b0;
    r_keep = 1'b0;
    take  = 1'b0;
    c_in_range = 32'(chars_seen) < PREFIX_BYTES;

    if (e_fire && (s1.mode == MODE_PATH_CHAR)) begin
      if (!path_ended) begin
        if (s1.data_value == 8'd0) begin
          path_ended_next = 1'b1;
        end else if (32'(chars_seen) < PATH_BYTES - 1) begin
          take = 1'b1;
        end
      end
      if (take) begin
        for (int i = 0; i < PREFIX_SLOTS; i++) begin
          if (c_in_range && (CMPW'(chars_seen) < CMPW'(prefix_lengths[i])) &&
              (row_eff[i] != s1.data_value)) begin
            still_matching_next[i] = 1'b0;
          end
        end
        if ((recent_chars == DOTENV_HEAD) && (s1.data_value == CHAR_V)) begin
          dotenv_seen_next = 1'b1;
        end
        recent_chars_next = {recent_chars[23:0], s1.data_value};
        chars_seen_next   = chars_seen + CW'(1);
      end
      if (s1.last) begin
        for (int i = 0; i < PREFIX_SLOTS; i++) begin
          if ((7'(i) < {2'b00, active_prefixes}) && (prefix_lengths[i] != 8'd0) &&
              (32'(prefix_lengths[i]) <= PREFIX_BYTES) && still_matching_next[i] &&
              (CMPW'(prefix_lengths[i]) <= CMPW'(chars_seen_next))) begin
            r_pm = 1'b1;
          end
        end
        r_dot  = dotenv_seen_next;
        r_keep = keep_all_opens || r_wi || r_pm || (check_dotenv && r_dot);
        // verdict given: path state back to reset values
        still_matching_next = '1;
        chars_seen_next     = '0;
        path_ended_next     = 1'b0;
        recent_chars_next   = '0;
        dotenv_seen_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      still_matching <= '1;
      chars_seen     <= '0;
      path_ended     <= 1'b0;
      recent_chars   <= '0;
      dotenv_seen    <= 1'b0;
      for (int i = 0; i < PREFIX_SLOTS; i++) begin
        prefix_lengths[i] <= 8'd0;
      end
    end else begin
      still_matching <= still_matching_next;
      chars_seen     <= chars_seen_next;
      path_ended     <= path_ended_next;
      recent_chars   <= recent_chars_next;
      dotenv_seen    <= dotenv_seen_next;
      if (e_fire && (s1.mode == MODE_PREFIX_LEN) && (32'(s1.slot) < PREFIX_SLOTS)) begin
        prefix_lengths[SLW'(s1.slot)] <= s1.data_value;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_fire && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (e_fire && has_result) begin
      keep_event     <= r_keep;
      write_intent   <= r_wi;
      prefix_matched <= r_pm;
      dotenv_found   <= r_dot;
    end
  end

`ifndef NO_ASSERTIONS
  a_keep_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid && (write_intent || prefix_matched) |-> keep_event)
    else $error("keep_event low with write intent or prefix match");

  a_path_cleared: assert property (@(posedge clk) disable iff (rst)
    e_fire && has_result |=> (chars_seen == '0) && !path_ended && !dotenv_seen &&
                             (still_matching == '1))
    else $error("path state not cleared after verdict");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !e_fire |-> !in_ready)
    else $error("input taken while execute stage stalled");

  a_chars_bound: assert property (@(posedge clk) disable iff (rst)
    32'(chars_seen) < PATH_BYTES)
    else $error("chars_seen beyond path buffer");
`endif

endmodule

// ===== sim/file_open_path_filter_core_tb.sv =====
module file_open_path_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fopf_pkg::*;

  // Block geometry (defaults of the core)
  localparam int SLOTS     = 16;
  localparam int ROW_BYTES = 64;
  localparam int PATH_MAX  = 256;

  // Write-ish open flags: WRONLY 0x1, RDWR 0x2, CREAT 0x40, TRUNC 0x200, APPEND 0x400
  localparam logic [31:0] WRITE_FLAGS = 32'h0000_0643;

  localparam logic [7:0] C_SLASH = 8'h2f;
  localparam logic [7:0] C_DOT   = 8'h2e;
  localparam logic [7:0] C_E     = 8'h65;
  localparam logic [7:0] C_N     = 8'h6e;
  localparam logic [7:0] C_V     = 8'h76;
  localparam logic [7:0] C_A     = 8'h61;
  localparam logic [7:0] C_T     = 8'h74;
  localparam logic [31:0] DOTENV_LEAD = {C_SLASH, C_DOT, C_E, C_N};

  // Mode code the core does not define; such beats are dropped
  localparam mode_e MODE_UNUSED = mode_e'(2'd3);

  // Cycles for a beat to clear the input register and the result stage
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic keep;
    logic wi;
    logic pm;
    logic de;
  } verdict_t;

  // One line of the directed plan: either a register write or an input beat
  typedef struct {
    bit                     reg_write;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    in_item_t               beat;
    bit                     typed;
    verdict_t               want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid   = 1'b0;
  logic        in_ready;
  mode_e       mode       = MODE_PREFIX_BYTE;
  logic [3:0]  slot       = '0;
  logic [5:0]  position   = '0;
  logic [7:0]  data_value = '0;
  logic [31:0] open_flags = '0;
  logic        last       = 1'b0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic keep_event;
  logic write_intent;
  logic prefix_matched;
  logic dotenv_found;

  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  file_open_path_filter_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .slot          (slot),
    .position      (position),
    .data_value    (data_value),
    .open_flags    (open_flags),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .keep_event    (keep_event),
    .write_intent  (write_intent),
    .prefix_matched(prefix_matched),
    .dotenv_found  (dotenv_found),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of the prefix table, the per-path tracking and
  // the three registers. Updated when a beat is accepted.
  // ---------------------------------------------------------------------------
  logic [7:0]  row_byte    [SLOTS][ROW_BYTES];
  bit          byte_loaded [SLOTS][ROW_BYTES];  // stimulus only reads loaded bytes
  logic [7:0]  row_len     [SLOTS];
  logic [15:0] agree;        // slot still agrees with the path so far
  logic [8:0]  char_count;   // characters taken into the path buffer
  bit          path_done;    // zero character seen
  logic [31:0] tail4;        // last four characters taken
  bit          saw_dotenv;

  bit         cfg_keep_all;
  bit         cfg_dotenv;
  logic [4:0] cfg_active;

  verdict_t verdict_q[$];  // verdicts predicted, oldest first

  int mismatches = 0;
  int items_sent = 0;
  int gap_pct    = 0;      // sender idle chance per cycle
  int stall_pct  = 0;      // receiver stall chance per cycle

  function automatic void reset_path_state();
    agree      = '1;
    char_count = '0;
    path_done  = 1'b0;
    tail4      = '0;
    saw_dotenv = 1'b0;
  endfunction

  function automatic void reset_filter_model();
    for (int i = 0; i < SLOTS; i++) begin
      row_len[i] = '0;
      for (int j = 0; j < ROW_BYTES; j++) begin
        row_byte[i][j]    = '0;
        byte_loaded[i][j] = 1'b0;
      end
    end
    cfg_keep_all = 1'b0;
    cfg_dotenv   = 1'b0;
    cfg_active   = '0;
    reset_path_state();
  endfunction

  // Applies one accepted beat; returns 1 with the verdict when one is due.
  function automatic bit filter_step(input in_item_t b, output verdict_t v);
    int n;
    int len;
    bit pm;
    bit wi;
    v = '0;
    case (b.mode)
      MODE_PREFIX_BYTE: begin
        row_byte[b.slot][b.position]    = b.data_value;
        byte_loaded[b.slot][b.position] = 1'b1;
        return 1'b0;
      end
      MODE_PREFIX_LEN: begin
        row_len[b.slot] = b.data_value;
        return 1'b0;
      end
      MODE_PATH_CHAR: ;
      default: return 1'b0;
    endcase

    // Characters after the terminator or past a full buffer are dropped
    if (!path_done) begin
      if (b.data_value == 8'd0) begin
        path_done = 1'b1;
      end else if (char_count < PATH_MAX - 1) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (char_count < row_len[i] && char_count < ROW_BYTES) begin
            if (row_byte[i][char_count] != b.data_value)
              agree[i] = 1'b0;
          end
        end
        if (tail4 == DOTENV_LEAD && b.data_value == C_V)
          saw_dotenv = 1'b1;
        tail4      = {tail4[23:0], b.data_value};
        char_count = char_count + 1'b1;
      end
    end
    if (!b.last)
      return 1'b0;

    n  = (cfg_active > SLOTS) ? SLOTS : int'(cfg_active);
    pm = 1'b0;
    for (int i = 0; i < n; i++) begin
      len = int'(row_len[i]);
      if (len > 0 && len <= ROW_BYTES && agree[i] && len <= char_count)
        pm = 1'b1;
    end
    wi     = (b.open_flags & WRITE_FLAGS) != 0;
    v.keep = cfg_keep_all || wi || pm || (cfg_dotenv && saw_dotenv);
    v.wi   = wi;
    v.pm   = pm;
    v.de   = saw_dotenv;
    reset_path_state();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("%s got %b want %b", name, got, want));
  endtask

  // Outputs sampled at the rising edge, before the core updates them
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict beat with nothing expected");
      end else begin
        want = verdict_q.pop_front();
        check_field("keep_event", keep_event, want.keep);
        check_field("write_intent", write_intent, want.wi);
        check_field("prefix_matched", prefix_matched, want.pm);
        check_field("dotenv_found", dotenv_found, want.de);
      end
    end
  end

  // Receiver: stalls at random, changes only at the falling edge
  always @(negedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_beat(input mode_e m, input logic [3:0] s,
                                         input logic [5:0] p, input logic [7:0] d,
                                         input logic [31:0] f, input logic l);
    in_item_t b;
    b.mode       = m;
    b.slot       = s;
    b.position   = p;
    b.data_value = d;
    b.open_flags = f;
    b.last       = l;
    return b;
  endfunction

  // Sends one beat; predicted verdict is queued at acceptance. A typed
  // verdict, when given, replaces the predicted one.
  task automatic push_beat(input in_item_t b, input bit typed = 1'b0,
                           input verdict_t want = '0);
    verdict_t v;
    bit       has;
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    mode       = b.mode;
    slot       = b.slot;
    position   = b.position;
    data_value = b.data_value;
    open_flags = b.open_flags;
    last       = b.last;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    has = filter_step(b, v);
    if (has)
      verdict_q.push_back(typed ? want : v);
    if (b.mode != MODE_UNUSED)
      items_sent++;
  endtask

  // Sender holds off until every predicted verdict has come back, then lets
  // the pipeline empty so that a register write finds the core idle.
  task automatic drain_verdicts();
    @(negedge clk);
    in_valid = 1'b0;
    while (verdict_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_KEEP_ALL_OPENS:  cfg_keep_all = val[0];
      REG_CHECK_DOTENV:    cfg_dotenv   = val[0];
      REG_ACTIVE_PREFIXES: cfg_active   = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------
  // Characters lean toward the ones that build "/.env"
  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0: return C_SLASH;
      1: return C_DOT;
      2: return C_E;
      3: return C_N;
      4: return C_V;
      5: return C_A;
      default: return 8'($urandom_range(255, 1));
    endcase
  endfunction

  // Flags mostly free of write bits so that keep_event is not stuck high
  function automatic logic [31:0] pick_flags();
    case ($urandom_range(3))
      0: return $urandom & ~WRITE_FLAGS;
      1: return $urandom;
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return ($urandom & ~WRITE_FLAGS) | (WRITE_FLAGS & (32'h1 << $urandom_range(31)));
    endcase
  endfunction

  // Longest length a slot may take without the core comparing a byte that
  // was never loaded. A fully loaded row takes any length.
  function automatic int longest_len(input int s);
    int run;
    run = 0;
    while (run < ROW_BYTES && byte_loaded[s][run])
      run++;
    return (run == ROW_BYTES) ? 255 : run;
  endfunction

  task automatic send_load_noise();
    int s;
    s = $urandom_range(SLOTS - 1);
    if ($urandom_range(1))
      push_beat(make_beat(MODE_PREFIX_BYTE, 4'(s), 6'($urandom_range(63)),
                          8'($urandom_range(255)), pick_flags(), 1'($urandom_range(1))));
    else
      push_beat(make_beat(MODE_PREFIX_LEN, 4'(s), 6'($urandom_range(63)),
                          8'($urandom_range(longest_len(s))), pick_flags(),
                          1'($urandom_range(1))));
  endtask

  task automatic send_noise();
    if ($urandom_range(2) == 0)
      push_beat(make_beat(MODE_UNUSED, 4'($urandom_range(15)), 6'($urandom_range(63)),
                          8'($urandom_range(255)), $urandom, 1'($urandom_range(1))));
    else
      send_load_noise();
  endtask

  // Loads a prefix into one slot: bytes first, then the length. Now and then
  // a full row, followed by length 64 or an invalid length above it; now and then length zero.
  task automatic send_prefix();
    int s;
    int plen;
    bit full;
    s    = $urandom_range(SLOTS - 1);
    full = $urandom_range(99) < 15;
    plen = full ? ROW_BYTES : $urandom_range(12, 1);
    for (int k = 0; k < plen; k++)
      push_beat(make_beat(MODE_PREFIX_BYTE, 4'(s), 6'(k),
                          ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pick_char(),
                          pick_flags(), 1'b0));
    if (full && $urandom_range(1))
      plen = $urandom_range(255, ROW_BYTES + 1);
    if ($urandom_range(99) < 8)
      plen = 0;
    push_beat(make_beat(MODE_PREFIX_LEN, 4'(s), 6'($urandom_range(63)), 8'(plen),
                        pick_flags(), 1'($urandom_range(1))));
  endtask

  // One path: often a loaded prefix (sometimes corrupted or cut short), then
  // random characters, maybe "/.env", maybe a terminator with trailing junk.
  // Loads may land between characters.
  task automatic send_path(input int tail_len);
    logic [7:0] txt[$];
    int s;
    int lim;
    int cut;
    if ($urandom_range(99) < 60) begin
      if ($urandom_range(99) < 70 && cfg_active > 0 && cfg_active < SLOTS)
        s = $urandom_range(cfg_active - 1);
      else
        s = $urandom_range(SLOTS - 1);
      lim = (row_len[s] > ROW_BYTES) ? ROW_BYTES : int'(row_len[s]);
      for (int k = 0; k < lim; k++)
        txt.push_back(row_byte[s][k]);
      if (lim > 0 && $urandom_range(99) < 25)
        txt[$urandom_range(lim - 1)] = pick_char();
      if (lim > 0 && $urandom_range(99) < 15) begin
        cut = $urandom_range(lim - 1);
        while (txt.size() > cut)
          void'(txt.pop_back());
      end
    end
    for (int k = 0; k < tail_len; k++)
      txt.push_back(pick_char());
    if ($urandom_range(99) < 30) begin
      txt.push_back(C_SLASH);
      txt.push_back(C_DOT);
      txt.push_back(C_E);
      txt.push_back(C_N);
      txt.push_back(C_V);
      repeat ($urandom_range(2)) txt.push_back(pick_char());
    end
    if ($urandom_range(99) < 20) begin
      txt.push_back(8'd0);
      repeat ($urandom_range(3, 1)) txt.push_back(pick_char());
    end
    if (txt.size() == 0)
      txt.push_back(pick_char());
    for (int k = 0; k < txt.size(); k++) begin
      if ($urandom_range(99) < 5)
        send_load_noise();
      push_beat(make_beat(MODE_PATH_CHAR, 4'($urandom_range(15)), 6'($urandom_range(63)),
                          txt[k], pick_flags(), k == txt.size() - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan
  // ---------------------------------------------------------------------------
  plan_row_t plan[$];

  function automatic void plan_beat(input mode_e m, input logic [3:0] s,
                                    input logic [5:0] p, input logic [7:0] d,
                                    input logic [31:0] f, input logic l,
                                    input bit typed = 1'b0, input verdict_t want = '0);
    plan_row_t r;
    r           = '{default: '0};
    r.beat      = make_beat(m, s, p, d, f, l);
    r.typed     = typed;
    r.want      = want;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r           = '{default: '0};
    r.reg_write = 1'b1;
    r.reg_idx   = idx;
    r.reg_val   = val;
    plan.push_back(r);
  endfunction

  // Verdict bits below read {keep, write_intent, prefix_matched, dotenv_found}
  function automatic void build_plan();
    // Registers at reset: nothing kept unless the flags show write intent
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_A, 32'h0, 1'b1, 1'b1, 4'b0000);
    plan_beat(MODE_PATH_CHAR, 4'd15, 6'd63, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'b1100);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, 8'hFF, ~WRITE_FLAGS, 1'b1, 1'b1, 4'b0000);
    // Unknown mode with last set: dropped, no verdict
    plan_beat(MODE_UNUSED, 4'd15, 6'd63, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    // Table loads; last on a load does nothing
    plan_beat(MODE_PREFIX_BYTE, 4'd15, 6'd63, 8'hFF, 32'h0, 1'b0);
    plan_beat(MODE_PREFIX_BYTE, 4'd0, 6'd0, C_SLASH, 32'h0, 1'b1);
    plan_beat(MODE_PREFIX_BYTE, 4'd0, 6'd1, C_T, 32'h0, 1'b0);
    plan_beat(MODE_PREFIX_LEN, 4'd0, 6'd0, 8'd2, 32'h0, 1'b1);
    plan_reg(REG_ACTIVE_PREFIXES, 5'd16);
    plan_reg(REG_CHECK_DOTENV, 5'd1);
    // "/.env": dotenv found and enabled; prefix "/t" fails at the dot
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_SLASH, 32'h0, 1'b0);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_DOT, 32'h0, 1'b0);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_E, 32'h0, 1'b0);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_N, 32'h0, 1'b0);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_V, 32'h0, 1'b1, 1'b1, 4'b1001);
    // Prefix match, terminator, then a character that must be ignored
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_SLASH, 32'h0, 1'b0);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_T, 32'h0, 1'b0);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, 8'h00, 32'h0, 1'b0);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_A, 32'h0, 1'b1);
    // Active count above table size; keep-all on
    plan_reg(REG_ACTIVE_PREFIXES, 5'd31);
    plan_reg(REG_KEEP_ALL_OPENS, 5'd1);
    // Path shorter than the prefix: no match, kept by keep-all
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_SLASH, 32'h0, 1'b1);
    // Zero length makes the slot invalid even on an agreeing path
    plan_beat(MODE_PREFIX_LEN, 4'd0, 6'd0, 8'd0, 32'h0, 1'b0);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_SLASH, 32'h0, 1'b0);
    plan_beat(MODE_PATH_CHAR, 4'd0, 6'd0, C_T, 32'h0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int active_sweep[8] = '{16, 31, 0, 5, 16, 1, 12, 9};

  initial begin : main_seq
    int phase_start;
    int next_pause;
    int r;

    reset_filter_model();
    build_plan();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, no idling
    foreach (plan[k]) begin
      if (plan[k].reg_write) begin
        drain_verdicts();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        push_beat(plan[k].beat, plan[k].typed, plan[k].want);
      end
    end

    // Random part: eight phases, each setting the registers and an idling
    // pattern (none, sender, receiver, both, in turn)
    next_pause = items_sent + $urandom_range(200, 100);
    for (int ph = 0; ph < 8; ph++) begin
      drain_verdicts();
      write_reg(REG_KEEP_ALL_OPENS, (ph == 2 || ph == 6) ? 5'd1 : 5'd0);
      write_reg(REG_CHECK_DOTENV, 5'(ph % 2));
      write_reg(REG_ACTIVE_PREFIXES, 5'(active_sweep[ph]));
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 57; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 28; stall_pct = 28; end
      endcase
      phase_start = items_sent;
      // Overlong path so that the buffer fills and later characters drop
      if (ph == 1 || ph == 6)
        send_path(270);
      while (items_sent - phase_start < 200) begin
        r = $urandom_range(99);
        if (r < 55)
          send_path($urandom_range(12));
        else if (r < 80)
          send_prefix();
        else
          send_noise();
        if (items_sent >= next_pause) begin
          drain_verdicts();
          next_pause = items_sent + $urandom_range(200, 100);
        end
      end
    end

    drain_verdicts();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0)
      $display("file_open_path_filter_core_tb OK");
    else
      $display("file_open_path_filter_core_tb NOT OK");
    $finish;
  end

  // Hang guard: far beyond the slowest correct run
  initial begin : hang_guard
    #5ms;
    $display("file_open_path_filter_core_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fopf_pkg.sv
rtl/file_open_path_filter_core.sv
sim/file_open_path_filter_core_tb.sv
